// ----- rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the protobuf field encoder: operation codes,
// wire types, byte source selects and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned FieldW  = 29;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WireW   = 3;
  localparam int unsigned TagW    = FieldW + WireW;

  typedef enum logic [FuncW-1:0] {
    FUNC_VARINT = 2'd0,
    FUNC_FIXED  = 2'd1,
    FUNC_LEN    = 2'd2,
    FUNC_DATA   = 2'd3
  } func_e;

  localparam logic [WireW-1:0] WT_VARINT = 3'd0;
  localparam logic [WireW-1:0] WT_LEN    = 3'd2;
  localparam logic [WireW-1:0] WT_FIXED  = 3'd5;

  typedef enum logic [1:0] {
    SRC_TAG  = 2'd0,
    SRC_VAR  = 2'd1,
    SRC_FIX  = 2'd2,
    SRC_DATA = 2'd3
  } src_e;

  typedef struct packed {
    logic load;
    logic emit;
    src_e src;
  } pfe_cmd_t;

  typedef struct packed {
    logic  tag_more;
    logic  val_more;
    logic  fix_last;
    func_e func;
  } pfe_status_t;

endpackage

// ----- rtl/protobuf_field_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// protobuf_field_encoder_unit
// Serializes one protobuf wire-format field or one payload data byte per
// input transaction into a byte stream, one output transaction per byte.
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid_i / in_stall_o carries func_i, fld_num_i and
//   value_i; output channel out_valid_o / out_stall_i carries out_byte_o and
//   last_o, with last_o set on the final byte of each input transaction.
//   a varint or length field gives up to 5 tag bytes plus up to 10 value
//   bytes, a fixed32 field up to 9 bytes, a data byte exactly 1 byte.
//   a taken input is loaded first; each byte is then registered for output.
//   one byte leaves the tag or value shift register per cycle while the
//   output is not stalled; the next item is taken only once the controller
//   is back in the idle state.
//   the input stalls while an item is being serialized; the output byte
//   register lets the next item be taken while the last byte still waits.
//   a stalled output holds its byte and halts every byte-emitting state.
//   reset clears the controller to idle with no output pending.
// ----------------------------------------------------------------------------
module protobuf_field_encoder_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pfe_pkg::FuncW-1:0]  func_i,
  input  logic [pfe_pkg::FieldW-1:0] fld_num_i,
  input  logic [pfe_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pfe_pkg::ByteW-1:0]  out_byte_o,
  output logic                       last_o
);

  pfe_pkg::pfe_cmd_t    cmd;
  pfe_pkg::pfe_status_t status;

  pfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfe_datapath u_datapath (
    .clk_i          (clk_i),
    .func_i         (func_i),
    .fld_num_i      (fld_num_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

endmodule

// ----- rtl/pfe_datapath.sv -----
// ----------------------------------------------------------------------------
// pfe_datapath
// Tag and value shift registers, fixed32 byte counter and the output byte
// register of the protobuf field encoder.
// ----------------------------------------------------------------------------
module pfe_datapath (
  input  logic                          clk_i,
  input  logic [pfe_pkg::FuncW-1:0]     func_i,
  input  logic [pfe_pkg::FieldW-1:0]    fld_num_i,
  input  logic [pfe_pkg::ValueW-1:0]    value_i,
  input  pfe_pkg::pfe_cmd_t             cmd_i,
  output pfe_pkg::pfe_status_t          status_o,
  output logic [pfe_pkg::ByteW-1:0]     out_byte_o,
  output logic                          last_o
);

  logic [pfe_pkg::TagW-1:0]   tag_q, tag_d;
  logic [pfe_pkg::ValueW-1:0] val_q, val_d;
  logic [1:0]                 cnt_q, cnt_d;
  pfe_pkg::func_e             func_q, func_d;
  logic [pfe_pkg::ByteW-1:0]  byte_q, byte_d;
  logic                       last_q, last_d;
  logic [pfe_pkg::WireW-1:0]  wire_type;
  logic                       tag_more, val_more, fix_last;

  assign tag_more = (tag_q[pfe_pkg::TagW-1:7] != '0);
  assign val_more = (val_q[pfe_pkg::ValueW-1:7] != '0);
  assign fix_last = (cnt_q == 2'd3);

  always_comb begin
    unique case (pfe_pkg::func_e'(func_i))
      pfe_pkg::FUNC_FIXED: wire_type = pfe_pkg::WT_FIXED;
      pfe_pkg::FUNC_LEN:   wire_type = pfe_pkg::WT_LEN;
      default:             wire_type = pfe_pkg::WT_VARINT;
    endcase
  end

  always_comb begin
    tag_d  = tag_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    func_d = func_q;
    byte_d = byte_q;
    last_d = last_q;
    if (cmd_i.load) begin
      tag_d  = {fld_num_i, wire_type};
      val_d  = value_i;
      cnt_d  = 2'd0;
      func_d = pfe_pkg::func_e'(func_i);
    end else if (cmd_i.emit) begin
      unique case (cmd_i.src)
        pfe_pkg::SRC_TAG: begin
          byte_d = {tag_more, tag_q[6:0]};
          last_d = 1'b0;
          tag_d  = tag_q >> 7;
        end
        pfe_pkg::SRC_VAR: begin
          byte_d = {val_more, val_q[6:0]};
          last_d = ~val_more;
          val_d  = val_q >> 7;
        end
        pfe_pkg::SRC_FIX: begin
          byte_d = val_q[7:0];
          last_d = fix_last;
          val_d  = val_q >> 8;
          cnt_d  = cnt_q + 2'd1;
        end
        default: begin
          byte_d = val_q[7:0];
          last_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    func_q <= func_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign status_o.tag_more = tag_more;
  assign status_o.val_more = val_more;
  assign status_o.fix_last = fix_last;
  assign status_o.func     = func_q;
  assign out_byte_o        = byte_q;
  assign last_o            = last_q;

endmodule

// ----- rtl/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller of the protobuf field encoder: walks tag, body and data phases
// and owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [pfe_pkg::FuncW-1:0] func_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  pfe_pkg::pfe_status_t      status_i,
  output pfe_pkg::pfe_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAG  = 3'd1;
  localparam logic [2:0] S_VAR  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_emit;
  logic       accept;

  assign can_emit   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.src    = pfe_pkg::SRC_DATA;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = (pfe_pkg::func_e'(func_i) == pfe_pkg::FUNC_DATA) ? S_DATA : S_TAG;
        end
      end
      S_TAG: begin
        cmd_o.src  = pfe_pkg::SRC_TAG;
        cmd_o.emit = can_emit;
        if (can_emit && !status_i.tag_more) begin
          state_d = (status_i.func == pfe_pkg::FUNC_FIXED) ? S_FIX : S_VAR;
        end
      end
      S_VAR: begin
        cmd_o.src  = pfe_pkg::SRC_VAR;
        cmd_o.emit = can_emit;
        if (can_emit && !status_i.val_more) begin
          state_d = S_IDLE;
        end
      end
      S_FIX: begin
        cmd_o.src  = pfe_pkg::SRC_FIX;
        cmd_o.emit = can_emit;
        if (can_emit && status_i.fix_last) begin
          state_d = S_IDLE;
        end
      end
      S_DATA: begin
        cmd_o.src  = pfe_pkg::SRC_DATA;
        cmd_o.emit = can_emit;
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives protobuf_field_encoder_unit with directed and random field
// transactions. A scoreboard predicts the serialized byte stream of each
// accepted input and checks every output byte and its last flag in order,
// under random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [pfe_pkg::ByteW-1:0] data;
  logic                      last;
} wire_byte_t;

class wire_scoreboard;
  wire_byte_t wire_q[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  function void push_byte(logic [pfe_pkg::ByteW-1:0] b);
    wire_byte_t e;
    e.data = b;
    e.last = 1'b0;
    wire_q.insert(wire_q.size(), e);
  endfunction

  function void push_varint(logic [pfe_pkg::ValueW-1:0] v);
    while (v > 64'h7F) begin
      push_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    push_byte({1'b0, v[6:0]});
  endfunction

  function void note_field(pfe_pkg::func_e f, logic [pfe_pkg::FieldW-1:0] fnum,
                           logic [pfe_pkg::ValueW-1:0] v);
    case (f)
      pfe_pkg::FUNC_VARINT: begin
        push_varint({32'd0, fnum, pfe_pkg::WT_VARINT});
        push_varint(v);
      end
      pfe_pkg::FUNC_FIXED: begin
        push_varint({32'd0, fnum, pfe_pkg::WT_FIXED});
        push_byte(v[7:0]);
        push_byte(v[15:8]);
        push_byte(v[23:16]);
        push_byte(v[31:24]);
      end
      pfe_pkg::FUNC_LEN: begin
        push_varint({32'd0, fnum, pfe_pkg::WT_LEN});
        push_varint(v);
      end
      default: begin
        push_byte(v[7:0]);
      end
    endcase
    wire_q[wire_q.size()-1].last = 1'b1;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_byte(logic [pfe_pkg::ByteW-1:0] b, logic last);
    wire_byte_t e;
    if (wire_q.size() == 0) begin
      report($sformatf("unexpected byte %02h last %0b", b, last));
    end else begin
      e = wire_q.pop_front();
      if (b !== e.data) begin
        report($sformatf("out_byte got %02h expected %02h", b, e.data));
      end
      if (last !== e.last) begin
        report($sformatf("last got %0b expected %0b on byte %02h", last, e.last, e.data));
      end
    end
  endtask

  function int pending();
    return wire_q.size();
  endfunction
endclass

module testbench;

  localparam int unsigned FuncW  = pfe_pkg::FuncW;
  localparam int unsigned FieldW = pfe_pkg::FieldW;
  localparam int unsigned ValueW = pfe_pkg::ValueW;
  localparam int unsigned ByteW  = pfe_pkg::ByteW;

  localparam logic [FieldW-1:0] MaxField = '1;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [FuncW-1:0]  func        = '0;
  logic [FieldW-1:0] fld_num     = '0;
  logic [ValueW-1:0] value       = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [ByteW-1:0]  out_byte;
  logic              last;

  int                send_pct    = 0;
  int                recv_pct    = 0;
  logic              hold_off    = 1'b0;

  wire_scoreboard    sb;

  protobuf_field_encoder_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .fld_num_i      (fld_num),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_o         (last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_byte(out_byte, last);
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  task sender_gap();
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  task drive_field(pfe_pkg::func_e f, logic [FieldW-1:0] fnum, logic [ValueW-1:0] v);
    sender_gap();
    in_valid     <= 1'b1;
    func         <= f;
    fld_num      <= fnum;
    value        <= v;
    do @(posedge clk); while (in_stall);
    sb.note_field(f, fnum, v);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [FieldW-1:0] rand_field();
    int nb;
    if ($urandom_range(49) == 0) return '0;
    nb = $urandom_range(1, FieldW);
    return FieldW'($urandom) >> (FieldW - nb);
  endfunction

  function logic [ValueW-1:0] rand_value();
    int                nb;
    logic [ValueW-1:0] v;
    nb = $urandom_range(0, ValueW);
    v  = {$urandom, $urandom};
    if (nb == 0) return '0;
    return v >> (ValueW - nb);
  endfunction

  task send_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 35) begin
        // length-delimited header followed by its payload bytes
        len = $urandom_range(0, 6);
        drive_field(pfe_pkg::FUNC_LEN, rand_field(), ValueW'(len));
        repeat (len) drive_field(pfe_pkg::FUNC_DATA, rand_field(), {$urandom, $urandom});
        sent += len + 1;
      end else begin
        drive_field(pfe_pkg::func_e'(FuncW'($urandom_range(0, 3))), rand_field(),
                    rand_value());
        sent++;
      end
    end
  endtask

  task send_directed();
    drive_field(pfe_pkg::FUNC_VARINT, 29'd1, 64'd0);
    drive_field(pfe_pkg::FUNC_VARINT, MaxField, '1);
    drive_field(pfe_pkg::FUNC_VARINT, 29'd15, 64'd127);
    drive_field(pfe_pkg::FUNC_VARINT, 29'd16, 64'd128);
    drive_field(pfe_pkg::FUNC_VARINT, 29'd0, 64'd1);
    drive_field(pfe_pkg::FUNC_VARINT, 29'd300, 64'h8000_0000_0000_0000);
    drive_field(pfe_pkg::FUNC_VARINT, 29'd2047, 64'h7FFF_FFFF_FFFF_FFFF);
    drive_field(pfe_pkg::FUNC_FIXED, 29'd1, 64'hFFFF_FFFF_0000_0000);
    drive_field(pfe_pkg::FUNC_FIXED, MaxField, 64'h0000_0000_DEAD_BEEF);
    drive_field(pfe_pkg::FUNC_FIXED, 29'd0, 64'd0);
    drive_field(pfe_pkg::FUNC_FIXED, 29'd5, '1);
    drive_field(pfe_pkg::FUNC_LEN, 29'd2, 64'd0);
    drive_field(pfe_pkg::FUNC_LEN, 29'd3, 64'd3);
    drive_field(pfe_pkg::FUNC_DATA, 29'd0, 64'd0);
    drive_field(pfe_pkg::FUNC_DATA, MaxField, 64'd255);
    drive_field(pfe_pkg::FUNC_DATA, 29'd7, 64'hFFFF_FFFF_FFFF_FF00);
    drive_field(pfe_pkg::FUNC_LEN, MaxField, 64'd300);
    drive_field(pfe_pkg::FUNC_LEN, 29'd0, '1);
    drive_field(pfe_pkg::FUNC_DATA, 29'd1, 64'h1234_5678_9ABC_DEF0);
    drive_field(pfe_pkg::FUNC_VARINT, 29'h1555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  initial begin
    #(12 * 500000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int waited;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct <= 32;
    recv_pct <= 84;
    @(posedge clk);
    send_directed();
    send_random(55);
    wait_drained();

    send_pct <= 84;
    recv_pct <= 32;
    send_random(55);
    wait_drained();

    send_pct <= 0;
    recv_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_random(55);

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pfe_pkg.sv
rtl/pfe_datapath.sv
rtl/pfe_ctrl.sv
rtl/protobuf_field_encoder_unit.sv
verif/testbench.sv
